@@ sv/ksm_pkg.sv @@
// Shared types and constants for the k-mer stream matcher.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ksm_pkg;

    localparam int CODE_W      = 62;
    localparam int POS_W       = 31;
    localparam int RUN_W       = 5;
    localparam int KLEN_W      = 5;
    localparam int IDX_OUT_W   = 10;
    localparam int MAX_K       = 31;
    localparam int DEF_ENTRIES = 1024;

    localparam logic [KLEN_W-1:0] KLEN_RESET = 5'd31;
    localparam logic [RUN_W-1:0]  RUN_MAX    = 5'd31;
    localparam logic [POS_W-1:0]  POS_MAX    = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        LS_ACCEPTED  = 2'd0,
        LS_DUPLICATE = 2'd1,
        LS_FULL      = 2'd2
    } t_load_status;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_GENOME = 1'b1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_MATCH = 1'b1;

    localparam logic STRAND_FWD = 1'b0;
    localparam logic STRAND_REV = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_CHECK,
        ST_EMIT_L,
        ST_EMIT_F,
        ST_EMIT_R
    } t_state;

    typedef enum logic [1:0] {
        PH_LOAD,
        PH_FWD,
        PH_REV
    } t_phase;

    typedef enum logic [1:0] {
        EM_LOAD,
        EM_FWD,
        EM_REV
    } t_emit;

    typedef struct packed {
        logic   accept;
        logic   start_probe;
        t_phase probe_sel;
        logic   step;
        logic   check;
        t_phase key_sel;
        logic   clr_wr;
        logic   emit;
        t_emit  emit_sel;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_load;
        logic go;
        logic slot_valid;
        logic slot_hit;
        logic out_free;
        logic hit_f;
        logic hit_r;
    } t_sts;

endpackage

`default_nettype wire

@@ sv/ksm_ctrl.sv @@
// Controller for the k-mer stream matcher: sequences clearing, probes and result beats.
// Depends on ksm_pkg; drives the datapath through t_cmd and reads t_sts.
`timescale 1ns / 1ps
`default_nettype none

module ksm_ctrl
    import ksm_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_phase <= PH_LOAD;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        o_cmd.key_sel  = r_phase;
        o_cmd.emit_sel = EM_LOAD;
        o_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (i_sts.is_load || i_sts.go) begin
                    n_phase = i_sts.is_load ? PH_LOAD : PH_FWD;
                    o_cmd.start_probe = 1'b1;
                    o_cmd.probe_sel = n_phase;
                    n_state = ST_WAIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_WAIT: n_state = ST_CHECK;
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_sts.slot_hit || !i_sts.slot_valid) begin
                    unique case (r_phase)
                        PH_LOAD: n_state = ST_EMIT_L;
                        PH_FWD: begin
                            n_phase = PH_REV;
                            o_cmd.start_probe = 1'b1;
                            o_cmd.probe_sel = PH_REV;
                            n_state = ST_WAIT;
                        end
                        default: n_state = ST_EMIT_F;
                    endcase
                end else begin
                    // collision: walk to the next slot
                    o_cmd.step = 1'b1;
                    n_state = ST_WAIT;
                end
            end
            ST_EMIT_L: begin
                o_cmd.emit_sel = EM_LOAD;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT_F: begin
                o_cmd.emit_sel = EM_FWD;
                if (!i_sts.hit_f) begin
                    n_state = i_sts.hit_r ? ST_EMIT_R : ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = i_sts.hit_r ? ST_EMIT_R : ST_IDLE;
                end
            end
            ST_EMIT_R: begin
                o_cmd.emit_sel = EM_REV;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_check_after_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CHECK |-> $past(r_state) == ST_WAIT)
        else $error("slot checked without a read cycle");
`endif

endmodule

`default_nettype wire

@@ sv/ksm_datapath.sv @@
// Datapath for the k-mer stream matcher: rolling codes, hashed slot memory, output register.
// Depends on ksm_pkg; controlled by ksm_ctrl through t_cmd / t_sts.
`timescale 1ns / 1ps
`default_nettype none

module ksm_datapath
    import ksm_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_ENTRIES
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  wire                    i_func,
    input  wire  [CODE_W-1:0]      i_entry_code,
    input  wire  [7:0]             i_base_char,
    input  wire                    i_seq_start,
    input  wire                    i_cfg_we,
    input  wire  [KLEN_W-1:0]      i_cfg_wdata,
    input  wire                    i_stall,
    output logic                   o_valid,
    output logic                   o_kind,
    output logic [1:0]             o_load_status,
    output logic [IDX_OUT_W-1:0]   o_kmer_index,
    output logic [POS_W-1:0]       o_start_position,
    output logic                   o_strand,
    output logic                   o_last
);

    localparam int SLOTS = 2 * TABLE_ENTRIES;
    localparam int SW    = $clog2(SLOTS);
    localparam int IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW    = $clog2(TABLE_ENTRIES + 1);
    localparam int DW    = 1 + CODE_W + IW;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [CW-1:0] CNT_FULL  = CW'(TABLE_ENTRIES);

    function automatic logic [SW-1:0] hash_code(input logic [CODE_W-1:0] code);
        logic [SW-1:0] h;
        h = '0;
        for (int i = 0; i < CODE_W; i++) h[i % SW] = h[i % SW] ^ code[i];
        // fold back into range when the slot count is not a power of two
        if (int'(h) >= SLOTS) h = h - SW'(SLOTS);
        return h;
    endfunction

    // slot memory: {valid, code, load index}
    logic [DW-1:0] mem [SLOTS];
    logic [DW-1:0] r_rdata;
    logic [SW-1:0] r_addr, r_clr_addr;

    logic [KLEN_W-1:0]   r_klen;
    logic                r_func;
    logic [CODE_W-1:0]   r_entry, r_fwd, r_rev;
    logic [RUN_W-1:0]    r_run;
    logic [POS_W-1:0]    r_cpos, r_sp;
    logic                r_go;
    logic [CW-1:0]       r_count;
    logic                r_hit_f, r_hit_r;
    logic [IW-1:0]       r_fidx, r_ridx, r_lidx;
    t_load_status        r_lstat;
    logic                r_ovalid;

    // genome update
    logic [KLEN_W-1:0] k;
    logic [1:0]        b;
    logic              bv;
    logic [CODE_W-1:0] fwd0, rev0, mask, n_fwd, n_rev;
    logic [RUN_W-1:0]  run0, n_run;
    logic [POS_W-1:0]  pos0, n_cpos;
    logic [6:0]        k2;

    always_comb begin
        k = r_klen;
        if (k == '0) k = KLEN_W'(1);
        if (k > KLEN_W'(MAX_K)) k = KLEN_W'(MAX_K);
        k2 = {1'b0, k, 1'b0};
        unique case (i_base_char)
            8'h41, 8'h61: begin b = 2'd0; bv = 1'b1; end
            8'h43, 8'h63: begin b = 2'd1; bv = 1'b1; end
            8'h47, 8'h67: begin b = 2'd2; bv = 1'b1; end
            8'h54, 8'h74: begin b = 2'd3; bv = 1'b1; end
            default:      begin b = 2'd0; bv = 1'b0; end
        endcase
        pos0 = i_seq_start ? '0 : r_cpos;
        fwd0 = i_seq_start ? '0 : r_fwd;
        rev0 = i_seq_start ? '0 : r_rev;
        run0 = i_seq_start ? '0 : r_run;
        n_cpos = (pos0 < POS_MAX) ? pos0 + POS_W'(1) : pos0;
        mask = (CODE_W'(1) << k2) - CODE_W'(1);
        if (bv) begin
            n_fwd = ({fwd0[CODE_W-3:0], 2'b00} | CODE_W'(b)) & mask;
            n_rev = (rev0 >> 2) | (CODE_W'(b ^ 2'd3) << (k2 - 7'd2));
            n_run = (run0 < RUN_MAX) ? run0 + RUN_W'(1) : run0;
        end else begin
            n_fwd = '0;
            n_rev = '0;
            n_run = '0;
        end
    end

    logic [CODE_W-1:0] key, probe_key;
    logic              slot_valid, slot_hit, load_fin, ins;
    logic [IW-1:0]     slot_idx;

    always_comb begin
        case (i_cmd.key_sel)
            PH_LOAD: key = r_entry;
            PH_FWD:  key = r_fwd;
            default: key = r_rev;
        endcase
        case (i_cmd.probe_sel)
            PH_LOAD: probe_key = r_entry;
            PH_FWD:  probe_key = r_fwd;
            default: probe_key = r_rev;
        endcase
        slot_valid = r_rdata[DW-1];
        slot_idx   = r_rdata[IW-1:0];
        slot_hit   = slot_valid && (r_rdata[DW-2:IW] == key);
        load_fin   = i_cmd.check && (i_cmd.key_sel == PH_LOAD) && (slot_hit || !slot_valid);
        ins        = load_fin && !slot_hit && (r_count < CNT_FULL);
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[r_addr];
        if (i_cmd.clr_wr) mem[r_clr_addr] <= '0;
        else if (ins) mem[r_addr] <= {1'b1, r_entry, r_count[IW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_probe) r_addr <= hash_code(probe_key);
        else if (i_cmd.step) r_addr <= (r_addr == LAST_SLOT) ? '0 : r_addr + SW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen     <= KLEN_RESET;
            r_clr_addr <= '0;
            r_count    <= '0;
            r_fwd      <= '0;
            r_rev      <= '0;
            r_run      <= '0;
            r_cpos     <= '0;
            r_ovalid   <= 1'b0;
            r_func     <= FUNC_LOAD;
            r_go       <= 1'b0;
        end else begin
            if (i_cfg_we) r_klen <= i_cfg_wdata;
            if (i_cmd.clr_wr) r_clr_addr <= r_clr_addr + SW'(1);
            if (ins) r_count <= r_count + CW'(1);
            if (i_cmd.accept) begin
                r_func <= i_func;
                r_go   <= 1'b0;
                if (i_func == FUNC_GENOME) begin
                    r_fwd  <= n_fwd;
                    r_rev  <= n_rev;
                    r_run  <= n_run;
                    r_cpos <= n_cpos;
                    r_go   <= bv && (n_run >= k);
                end
            end
            if (i_cmd.emit) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_entry <= i_entry_code;
            r_sp    <= pos0 - POS_W'(k - KLEN_W'(1));
            r_hit_f <= 1'b0;
            r_hit_r <= 1'b0;
        end
        if (i_cmd.check && slot_hit) begin
            if (i_cmd.key_sel == PH_FWD) begin
                r_hit_f <= 1'b1;
                r_fidx  <= slot_idx;
            end else if (i_cmd.key_sel == PH_REV) begin
                r_hit_r <= 1'b1;
                r_ridx  <= slot_idx;
            end
        end
        if (load_fin) begin
            if (slot_hit) begin
                r_lstat <= LS_DUPLICATE;
                r_lidx  <= slot_idx;
            end else if (r_count < CNT_FULL) begin
                r_lstat <= LS_ACCEPTED;
                r_lidx  <= r_count[IW-1:0];
            end else begin
                r_lstat <= LS_FULL;
                r_lidx  <= '0;
            end
        end
        if (i_cmd.emit) begin
            unique case (i_cmd.emit_sel)
                EM_LOAD: begin
                    o_kind           <= KIND_LOAD;
                    o_load_status    <= r_lstat;
                    o_kmer_index     <= IDX_OUT_W'(r_lidx);
                    o_start_position <= '0;
                    o_strand         <= STRAND_FWD;
                    o_last           <= 1'b1;
                end
                EM_FWD: begin
                    o_kind           <= KIND_MATCH;
                    o_load_status    <= LS_ACCEPTED;
                    o_kmer_index     <= IDX_OUT_W'(r_fidx);
                    o_start_position <= r_sp;
                    o_strand         <= STRAND_FWD;
                    o_last           <= !r_hit_r;
                end
                default: begin
                    o_kind           <= KIND_MATCH;
                    o_load_status    <= LS_ACCEPTED;
                    o_kmer_index     <= IDX_OUT_W'(r_ridx);
                    o_start_position <= r_sp;
                    o_strand         <= STRAND_REV;
                    o_last           <= 1'b1;
                end
            endcase
        end
    end

    assign o_valid = r_ovalid;

    always_comb begin
        o_sts.clr_done   = (r_clr_addr == LAST_SLOT);
        o_sts.is_load    = (r_func == FUNC_LOAD);
        o_sts.go         = r_go;
        o_sts.slot_valid = slot_valid;
        o_sts.slot_hit   = slot_hit;
        o_sts.out_free   = !r_ovalid || !i_stall;
        o_sts.hit_f      = r_hit_f;
        o_sts.hit_r      = r_hit_r;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("entry count beyond table size");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_ovalid || !i_stall))
        else $error("result beat overwritten while stalled");
    a_insert_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ins |-> !slot_valid && !i_cmd.clr_wr)
        else $error("insert into occupied slot");
`endif

endmodule

`default_nettype wire

@@ sv/kmer_stream_matcher_unit.sv @@
// Top level of the k-mer stream matcher: controller plus datapath.
// Depends on ksm_pkg, ksm_ctrl and ksm_datapath.
//
// Input channel (i_valid / o_stall): func 0 beats load a 62-bit k-mer code
// into a hashed table of 2*TABLE_ENTRIES slots; func 1 beats carry one
// genome character. Output channel (o_valid / i_stall): one load-status
// beat per load, zero to two match beats per character (forward first).
// A beat is taken when valid is high and stall is low.
// Timing: one item at a time. A load walks the slot memory by linear
// probing until it finds its code or an empty slot; a character that
// reaches a full k-mer probes the slot memory twice, forward then
// reverse, and other characters make no probe.
// Reset (synchronous, i_rst_n low) starts a clearing pass over every slot
// of the slot memory; o_stall stays high until it ends. The k-mer
// length register (i_cfg_we / i_cfg_wdata) resets to 31 and may be written
// at any time while idle.
// When the receiver stalls, the result beat holds in the output register and
// the controller waits before issuing the next beat.
`timescale 1ns / 1ps
`default_nettype none

module kmer_stream_matcher_unit
    import ksm_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_ENTRIES
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire                  i_func,
    input  wire  [CODE_W-1:0]    i_entry_code,
    input  wire  [7:0]           i_base_char,
    input  wire                  i_seq_start,
    input  wire                  i_cfg_we,
    input  wire  [KLEN_W-1:0]    i_cfg_wdata,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic                 o_kind,
    output logic [1:0]           o_load_status,
    output logic [IDX_OUT_W-1:0] o_kmer_index,
    output logic [POS_W-1:0]     o_start_position,
    output logic                 o_strand,
    output logic                 o_last
);

    t_cmd cmd;
    t_sts sts;

    ksm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ksm_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_func           (i_func),
        .i_entry_code     (i_entry_code),
        .i_base_char      (i_base_char),
        .i_seq_start      (i_seq_start),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_kind           (o_kind),
        .o_load_status    (o_load_status),
        .o_kmer_index     (o_kmer_index),
        .o_start_position (o_start_position),
        .o_strand         (o_strand),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for kmer_stream_matcher_unit: drives load and genome beats,
// predicts load status and both-strand matches, and checks every result beat.
// Depends on ksm_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
    import ksm_pkg::*;

    localparam int  CYCLE_LIMIT = 900000;
    localparam int  ENTRIES     = 1024;
    localparam logic [63:0] CODE_MASK = (64'd1 << CODE_W) - 64'd1;

    typedef struct {
        logic                 kind;
        logic [1:0]           status;
        logic [IDX_OUT_W-1:0] idx;
        logic [POS_W-1:0]     pos;
        logic                 strand;
        logic                 last;
    } t_result;

    class kmer_scoreboard;
        logic [CODE_W-1:0] codes[ENTRIES];
        bit                used[ENTRIES];
        int                count;
        logic [63:0]       fwd, rev;
        int                run;
        logic [POS_W-1:0]  pos;
        logic [KLEN_W-1:0] klen;
        t_result           pending[$];
        int                errors;

        function new();
            count = 0; fwd = 0; rev = 0; run = 0; pos = 0; klen = KLEN_RESET; errors = 0;
            foreach (used[i]) used[i] = 0;
        endfunction

        function int lookup(logic [63:0] code);
            for (int i = 0; i < count; i++)
                if (used[i] && codes[i] == code[CODE_W-1:0]) return i;
            return -1;
        endfunction

        function void add(logic kind, logic [1:0] st, int idx, logic [POS_W-1:0] p,
                          logic strand, logic last);
            t_result r;
            r.kind = kind; r.status = st; r.idx = idx[IDX_OUT_W-1:0];
            r.pos = p; r.strand = strand; r.last = last;
            pending.push_back(r);
        endfunction

        // Predict the results of one accepted input beat.
        function void note_input(logic func, logic [CODE_W-1:0] code, logic [7:0] ch,
                                 logic start);
            int hit, k, b, f, r;
            logic [63:0] mask;
            logic [POS_W-1:0] p;
            if (func == FUNC_LOAD) begin
                hit = lookup({2'b00, code});
                if (hit >= 0) add(KIND_LOAD, LS_DUPLICATE, hit, '0, STRAND_FWD, 1'b1);
                else if (count >= ENTRIES) add(KIND_LOAD, LS_FULL, 0, '0, STRAND_FWD, 1'b1);
                else begin
                    codes[count] = code; used[count] = 1;
                    add(KIND_LOAD, LS_ACCEPTED, count, '0, STRAND_FWD, 1'b1);
                    count++;
                end
                return;
            end
            if (start) begin
                pos = 0; fwd = 0; rev = 0; run = 0;
            end
            k = (klen == 0) ? 1 : int'(klen);
            mask = (64'd1 << (2 * k)) - 64'd1;
            p = pos;
            if (pos != POS_MAX) pos++;
            case (ch)
                "A", "a": b = 0;
                "C", "c": b = 1;
                "G", "g": b = 2;
                "T", "t": b = 3;
                default:  b = -1;
            endcase
            if (b < 0) begin
                fwd = 0; rev = 0; run = 0;
                return;
            end
            fwd = ((fwd << 2) | 64'(b)) & mask;
            rev = ((rev >> 2) | (64'(b ^ 3) << (2 * (k - 1)))) & CODE_MASK;
            if (run < 31) run++;
            if (run >= k) begin
                p = p - POS_W'(k - 1);
                f = lookup(fwd);
                r = lookup(rev);
                if (f >= 0) add(KIND_MATCH, LS_ACCEPTED, f, p, STRAND_FWD, r < 0);
                if (r >= 0) add(KIND_MATCH, LS_ACCEPTED, r, p, STRAND_REV, 1'b1);
            end
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat kind=%0d idx=%0d", got.kind, got.idx));
                return;
            end
            exp = pending.pop_front();
            if (got.kind !== exp.kind)
                report($sformatf("kind %0d, want %0d", got.kind, exp.kind));
            if (got.status !== exp.status)
                report($sformatf("load_status %0d, want %0d", got.status, exp.status));
            if (got.idx !== exp.idx)
                report($sformatf("kmer_index %0d, want %0d", got.idx, exp.idx));
            if (got.pos !== exp.pos)
                report($sformatf("start_position %0d, want %0d", got.pos, exp.pos));
            if (got.strand !== exp.strand)
                report($sformatf("strand %0d, want %0d", got.strand, exp.strand));
            if (got.last !== exp.last)
                report($sformatf("last %0d, want %0d", got.last, exp.last));
        endfunction
    endclass

    logic                 i_clk = 0, i_rst_n = 0;
    logic                 i_valid = 0, i_func = 0, i_seq_start = 0;
    logic [CODE_W-1:0]    i_entry_code = '0;
    logic [7:0]           i_base_char = '0;
    logic                 i_cfg_we = 0;
    logic [KLEN_W-1:0]    i_cfg_wdata = '0;
    logic                 i_stall = 0;
    logic                 o_stall, o_valid, o_kind, o_strand, o_last;
    logic [1:0]           o_load_status;
    logic [IDX_OUT_W-1:0] o_kmer_index;
    logic [POS_W-1:0]     o_start_position;

    kmer_scoreboard sb = new();
    bit  calm = 0;          // no gaps on either side
    bit  hold_req = 0;
    int  cycles = 0;
    int  cur_k = 31;
    logic [CODE_W-1:0] known[$];

    kmer_stream_matcher_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_entry_code(i_entry_code), .i_base_char(i_base_char),
        .i_seq_start(i_seq_start), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid), .i_stall(i_stall), .o_kind(o_kind),
        .o_load_status(o_load_status), .o_kmer_index(o_kmer_index),
        .o_start_position(o_start_position), .o_strand(o_strand), .o_last(o_last)
    );

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.kind = o_kind; got.status = o_load_status; got.idx = o_kmer_index;
            got.pos = o_start_position; got.strand = o_strand; got.last = o_last;
            sb.check_result(got);
        end
    end

    // Receiver: random stalls per beat, one long hold on request.
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                i_stall <= 1;
                repeat (400) @(posedge i_clk);
            end
            n = calm ? 0 : $urandom_range(0, 16);
            if (n > 0) begin
                i_stall <= 1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send(logic func, logic [CODE_W-1:0] code, logic [7:0] ch, logic start);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1; i_func <= func; i_entry_code <= code;
        i_base_char <= ch; i_seq_start <= start;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(func, code, ch, start);
    endtask

    task automatic load(logic [CODE_W-1:0] code);
        send(FUNC_LOAD, code, 8'($urandom), 1'($urandom));
        known.push_back(code);
    endtask

    task automatic base(int b, logic start);
        logic [7:0] ch;
        string lower, upper;
        lower = "acgt";
        upper = "ACGT";
        ch = $urandom_range(0, 1) ? lower[b] : upper[b];
        send(FUNC_GENOME, CODE_W'({$urandom, $urandom}), ch, start);
    endtask

    // Wait until every predicted result beat has been taken.
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Hold off the input, drain, then write the length register.
    task automatic set_len(logic [KLEN_W-1:0] k);
        i_valid <= 0;
        drain();
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_wdata <= k;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.klen = k;
        cur_k = (k == 0) ? 1 : int'(k);
    endtask

    // Stream a k-mer, forward or as its reverse complement.
    task automatic stream_kmer(logic [CODE_W-1:0] code, bit revcomp, logic start);
        int b;
        for (int i = 0; i < cur_k; i++) begin
            b = revcomp ? (3 - int'(code[2 * i +: 2])) : int'(code[2 * (cur_k - 1 - i) +: 2]);
            base(b, start && i == 0);
        end
    endtask

    function automatic logic [CODE_W-1:0] rand_code(int k);
        logic [63:0] m;
        m = (64'd1 << (2 * k)) - 64'd1;
        return CODE_W'({$urandom, $urandom} & m);
    endfunction

    initial begin
        int lens[10] = '{2, 0, 3, 7, 12, 31, 1, 20, 5, 16};
        int sel;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: palindrome, duplicates, case, breaks at k=2.
        set_len(5'd2);
        load(CODE_W'(4'b0011));
        load('1);
        load('0);
        load(CODE_W'(4'b0011));
        load('1);
        base(0, 1'b1); base(3, 1'b0);
        send(FUNC_GENOME, '0, "a", 1'b0);
        send(FUNC_GENOME, '0, "N", 1'b0);
        send(FUNC_GENOME, '0, "c", 1'b0);
        send(FUNC_GENOME, '0, "g", 1'b0);
        send(FUNC_GENOME, '0, "T", 1'b0);
        send(FUNC_GENOME, '1, 8'hFF, 1'b1);
        send(FUNC_GENOME, '0, 8'h00, 1'b0);
        send(FUNC_GENOME, '0, "A", 1'b0);

        // Random phases over several lengths.
        foreach (lens[p]) begin
            set_len(KLEN_W'(lens[p]));
            calm = (p % 3 == 2);
            if (p == 3) hold_req = 1'b1;
            for (int n = 0; n < 60; ) begin
                sel = $urandom_range(0, 99);
                if (sel < 15) begin
                    load(rand_code(cur_k)); n++;
                end else if (sel < 20 && known.size() > 0) begin
                    load(known[$urandom_range(0, known.size() - 1)]); n++;
                end else if (sel < 75 && known.size() > 0) begin
                    stream_kmer(known[$urandom_range(0, known.size() - 1)],
                                1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
                    n += cur_k;
                end else begin
                    if ($urandom_range(0, 1))
                        send(FUNC_GENOME, '0, 8'($urandom_range(0, 255)),
                             $urandom_range(0, 9) == 0);
                    else
                        base($urandom_range(0, 3), $urandom_range(0, 19) == 0);
                    n++;
                end
            end
        end

        // Fill the table, then push past full with new codes and duplicates.
        set_len(5'd31);
        calm = 0;
        while (sb.count < ENTRIES)
            send(FUNC_LOAD, CODE_W'({$urandom, $urandom}), 8'($urandom), 1'($urandom));
        for (int n = 0; n < 20; n++) begin
            send(FUNC_LOAD, CODE_W'({$urandom, $urandom}), 8'd0, 1'b0);
            load(known[$urandom_range(0, known.size() - 1)]);
        end
        set_len(5'd3);
        for (int n = 0; n < 60; n++)
            base($urandom_range(0, 3), $urandom_range(0, 29) == 0);

        i_valid <= 0;
        drain();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
